// ===== sv/gif_pkg.sv =====
// ----------------------------------------------------------------------------
// gif_pkg
// Shared types and constants for the grid bracket-and-weight finder.
// ----------------------------------------------------------------------------
package gif_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIODIC_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_LENGTH = 2'd2;

    localparam logic [6:0]  POINT_COUNT_RST   = 7'd2;
    localparam logic [30:0] PERIOD_LENGTH_RST = 31'd411775;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [16:0] ONE_Q16 = 17'h10000;

    // one restoring step per cycle
    localparam logic [5:0] MOD_STEPS = 6'd32;
    localparam logic [5:0] DIV_STEPS = 6'd17;

    typedef struct packed {
        logic               cmd;
        logic [5:0]         entry_index;
        logic signed [31:0] grid_value;
        logic signed [31:0] query_value;
    } in_item_t;

    typedef struct packed {
        logic [5:0]  index_low;
        logic [5:0]  index_high;
        logic [16:0] weight_low;
        logic [16:0] weight_high;
    } out_item_t;

endpackage

// ===== sv/grid_interp_weight_finder_core.sv =====
// ----------------------------------------------------------------------------
// grid_interp_weight_finder_core
// Grid bracket search and linear weight computation on one shared subtractor.
// Load: writes one grid entry, no result. Query: periodic values are first
// reduced by the period; non-periodic values beyond an end point clamp to it;
// others are searched, then weighted by division. One 35-bit subtractor does the
// search compares, the 32-step remainder and the 17-step quotient; one item at a
// time (busy high). done strobes one cycle per result; the receiver cannot stall it.
// rst_n async: config registers to reset values, sequencer idle; grid RAM not cleared.
// ----------------------------------------------------------------------------
module grid_interp_weight_finder_core #(
    parameter int GRID_DEPTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  gif_pkg::in_item_t             item,
    output logic                          done,
    output gif_pkg::out_item_t            result,
    input  logic                          cfg_wr_en,
    input  logic [gif_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gif_pkg::CFG_DATA_W-1:0] cfg_data
);
    import gif_pkg::*;

    localparam int AW = (GRID_DEPTH > 1) ? $clog2(GRID_DEPTH) : 1;
    localparam int CW = AW + 1;
    localparam int NW = (CW > 7) ? CW : 7;
    localparam int EW = (CW > 6) ? CW : 6;

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b0000000001,
        ST_MOD      = 10'b0000000010,
        ST_MOD_FIX  = 10'b0000000100,
        ST_FIRST    = 10'b0000001000,
        ST_LAST     = 10'b0000010000,
        ST_WRAP_DEN = 10'b0000100000,
        ST_SEARCH   = 10'b0001000000,
        ST_PREV     = 10'b0010000000,
        ST_DEN      = 10'b0100000000,
        ST_DIV      = 10'b1000000000
    } state_t;

    // configuration
    logic [6:0]  point_count_reg;
    logic        periodic_mode_reg;
    logic [30:0] period_length_reg;

    // sequencer and datapath
    state_t             state_reg, state_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic signed [31:0] x_reg, x_next;
    logic               neg_reg, neg_next;
    logic [31:0]        mag_reg, mag_next;
    logic [33:0]        rem_reg, rem_next;
    logic [33:0]        den_reg, den_next;
    logic [15:0]        q_reg, q_next;
    logic [AW-1:0]      k_reg, k_next;
    logic [AW-1:0]      lo_reg, lo_next;
    logic [AW-1:0]      hi_reg, hi_next;
    logic [AW-1:0]      addr_reg, addr_next;
    logic signed [31:0] ghi_reg, ghi_next;

    logic signed [31:0] grid_mem [GRID_DEPTH];
    logic signed [31:0] rd_data_reg;

    logic               done_reg;
    out_item_t          result_reg;

    // shared subtractor
    logic signed [33:0] alu_a, alu_b;
    logic signed [34:0] alu_diff;
    logic               alu_ge;

    logic               fin;
    logic [AW-1:0]      fin_lo, fin_hi;
    logic [16:0]        fin_w;

    logic [NW-1:0]      n_wide;
    logic [CW-1:0]      n_eff;
    logic [AW-1:0]      last_idx;
    logic [30:0]        p_eff;
    logic [33:0]        mod_shift;
    logic [32:0]        div_sel;
    logic [CW-1:0]      k_plus;
    logic               accept;
    logic               wr_en;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign wr_en  = accept && (item.cmd == CMD_LOAD)
                    && (EW'(item.entry_index) < EW'(GRID_DEPTH));

    assign done   = done_reg;
    assign result = result_reg;

    always_comb
    begin
        n_wide = NW'(point_count_reg);
        if (n_wide < NW'(2))
        begin
            n_wide = NW'(2);
        end
        if (n_wide > NW'(GRID_DEPTH))
        begin
            n_wide = NW'(GRID_DEPTH);
        end
    end

    assign n_eff    = CW'(n_wide);
    assign last_idx = AW'(n_eff - CW'(1));
    assign p_eff    = (period_length_reg == 31'd0) ? 31'd1 : period_length_reg;
    assign k_plus   = CW'(k_reg) + CW'(1);

    assign mod_shift = {1'b0, rem_reg[31:0], mag_reg[31]};
    assign alu_diff  = 35'(alu_a) - 35'(alu_b);
    assign alu_ge    = ~alu_diff[34];
    assign div_sel   = alu_ge ? alu_diff[32:0] : rem_reg[32:0];

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg   <= POINT_COUNT_RST;
            periodic_mode_reg <= 1'b0;
            period_length_reg <= PERIOD_LENGTH_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_POINT_COUNT:   point_count_reg   <= cfg_data[6:0];
                REG_PERIODIC_MODE: periodic_mode_reg <= cfg_data[0];
                REG_PERIOD_LENGTH: period_length_reg <= cfg_data[30:0];
                default:           ;
            endcase
        end
    end

    // grid RAM, read data registered; read address follows the sequencer
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            grid_mem[AW'(item.entry_index)] <= item.grid_value;
        end
        rd_data_reg <= grid_mem[addr_next];
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        x_next     = x_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        q_next     = q_reg;
        k_next     = k_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        addr_next  = addr_reg;
        ghi_next   = ghi_reg;
        alu_a      = 34'sd0;
        alu_b      = 34'sd0;
        fin        = 1'b0;
        fin_lo     = '0;
        fin_hi     = '0;
        fin_w      = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (item.cmd == CMD_QUERY))
                begin
                    x_next   = item.query_value;
                    neg_next = item.query_value[31];
                    mag_next = item.query_value[31] ? 32'(-item.query_value)
                                                    : 32'(item.query_value);
                    rem_next = '0;
                    cnt_next = MOD_STEPS;
                    if (periodic_mode_reg)
                    begin
                        state_next = ST_MOD;
                    end
                    else
                    begin
                        addr_next  = '0;
                        state_next = ST_FIRST;
                    end
                end
            end

            // restoring remainder of |v| by the period
            ST_MOD:
            begin
                alu_a    = mod_shift;
                alu_b    = 34'({3'b000, p_eff});
                rem_next = alu_ge ? alu_diff[33:0] : mod_shift;
                mag_next = {mag_reg[30:0], 1'b0};
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    state_next = ST_MOD_FIX;
                end
            end

            // negative operand with nonzero remainder wraps to p - rem
            ST_MOD_FIX:
            begin
                alu_a = 34'({3'b000, p_eff});
                alu_b = rem_reg;
                if (neg_reg && (rem_reg != '0))
                begin
                    x_next = alu_diff[31:0];
                end
                else
                begin
                    x_next = rem_reg[31:0];
                end
                addr_next  = last_idx;
                state_next = ST_LAST;
            end

            ST_FIRST:
            begin
                alu_a = 34'(rd_data_reg);
                alu_b = 34'(x_reg);
                if (alu_ge)
                begin
                    fin        = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    addr_next  = last_idx;
                    state_next = ST_LAST;
                end
            end

            ST_LAST:
            begin
                alu_a = 34'(x_reg);
                alu_b = 34'(rd_data_reg);
                if (alu_ge && !periodic_mode_reg)
                begin
                    fin        = 1'b1;
                    fin_lo     = last_idx;
                    fin_hi     = last_idx;
                    state_next = ST_IDLE;
                end
                else if (alu_ge)
                begin
                    // wrap segment: last point to period end
                    rem_next   = alu_diff[33:0];
                    lo_next    = last_idx;
                    hi_next    = '0;
                    state_next = ST_WRAP_DEN;
                end
                else
                begin
                    k_next     = periodic_mode_reg ? '0 : AW'(1);
                    addr_next  = periodic_mode_reg ? '0 : AW'(1);
                    state_next = ST_SEARCH;
                end
            end

            ST_WRAP_DEN:
            begin
                alu_a      = 34'({3'b000, p_eff});
                alu_b      = 34'(rd_data_reg);
                den_next   = alu_diff[33:0];
                q_next     = '0;
                cnt_next   = DIV_STEPS;
                state_next = ST_DIV;
            end

            // first point not below the value
            ST_SEARCH:
            begin
                alu_a = 34'(rd_data_reg);
                alu_b = 34'(x_reg);
                if (alu_ge)
                begin
                    if (k_reg == '0)
                    begin
                        fin        = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        hi_next    = k_reg;
                        lo_next    = k_reg - AW'(1);
                        addr_next  = k_reg - AW'(1);
                        ghi_next   = rd_data_reg;
                        state_next = ST_PREV;
                    end
                end
                else if (k_plus >= n_eff)
                begin
                    fin        = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    k_next    = k_reg + AW'(1);
                    addr_next = k_reg + AW'(1);
                end
            end

            ST_PREV:
            begin
                alu_a      = 34'(x_reg);
                alu_b      = 34'(rd_data_reg);
                rem_next   = alu_diff[33:0];
                state_next = ST_DEN;
            end

            ST_DEN:
            begin
                alu_a      = 34'(ghi_reg);
                alu_b      = 34'(rd_data_reg);
                den_next   = alu_diff[33:0];
                q_next     = '0;
                cnt_next   = DIV_STEPS;
                state_next = ST_DIV;
            end

            // restoring quotient, numerator <= divisor so 17 bits suffice
            ST_DIV:
            begin
                alu_a    = rem_reg;
                alu_b    = den_reg;
                q_next   = {q_reg[14:0], alu_ge};
                rem_next = {div_sel, 1'b0};
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    fin        = 1'b1;
                    fin_lo     = lo_reg;
                    fin_hi     = hi_reg;
                    fin_w      = {q_reg, alu_ge};
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            addr_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= fin;
            addr_reg  <= addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        neg_reg <= neg_next;
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
        k_reg   <= k_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        ghi_reg <= ghi_next;
        if (fin)
        begin
            result_reg.index_low   <= 6'(fin_lo);
            result_reg.index_high  <= 6'(fin_hi);
            result_reg.weight_high <= fin_w;
            result_reg.weight_low  <= ONE_Q16 - fin_w;
        end
    end

endmodule
